FILE: rtl/core/asc_pkg.sv
// Package for the accelerometer sample scaler: format decode tables,
// queue entry types and the axis index type.
// No dependencies; the front end, queue, back end and top level import it.
`default_nettype none

package asc_pkg;

    localparam int AXES = 3;

    // Format byte field codes.
    localparam logic [1:0] RANGE_2G     = 2'd0;
    localparam logic [1:0] RANGE_4G     = 2'd1;
    localparam logic [1:0] RANGE_8G     = 2'd2;
    localparam logic [1:0] RANGE_ALT_2G = 2'd3;

    localparam logic [1:0] RES_128      = 2'd0;
    localparam logic [1:0] RES_2048     = 2'd1;
    localparam logic [1:0] RES_65536    = 2'd2;
    localparam logic [1:0] RES_ALT_2048 = 2'd3;

    localparam logic [1:0] SCALE_1E2    = 2'd0;
    localparam logic [1:0] SCALE_1E3    = 2'd1;
    localparam logic [1:0] SCALE_1E4    = 2'd2;
    localparam logic [1:0] SCALE_1E5    = 2'd3;

    localparam logic [6:0] WHOLE_MAX    = 7'd127;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef struct packed {
        logic        neg;
        logic [15:0] mag;
        logic [15:0] low;   // magnitude bits below the binary point
    } axis_entry_t;

    typedef struct packed {
        axis_entry_t [AXES-1:0] axes;
        logic [3:0]             shift;
        logic [16:0]            scale;
        logic [1:0]             range_code;
        logic [7:0]             seq;
    } item_t;

    // counts and g are powers of two, so g / counts is a right shift.
    function automatic logic [3:0] shift_of(logic [1:0] rng, logic [1:0] res);
        logic [4:0] counts_log;
        logic [4:0] g_log;
        unique case (res)
            RES_128:      counts_log = 5'd7;
            RES_2048:     counts_log = 5'd11;
            RES_65536:    counts_log = 5'd16;
            RES_ALT_2048: counts_log = 5'd11;
            default:      counts_log = 5'd11;
        endcase
        unique case (rng)
            RANGE_2G:     g_log = 5'd1;
            RANGE_4G:     g_log = 5'd2;
            RANGE_8G:     g_log = 5'd3;
            RANGE_ALT_2G: g_log = 5'd1;
            default:      g_log = 5'd1;
        endcase
        return 4'(counts_log - g_log);
    endfunction

    function automatic logic [16:0] scale_of(logic [1:0] code);
        logic [16:0] s;
        unique case (code)
            SCALE_1E2: s = 17'd100;
            SCALE_1E3: s = 17'd1000;
            SCALE_1E4: s = 17'd10000;
            SCALE_1E5: s = 17'd100000;
            default:   s = 17'd100;
        endcase
        return s;
    endfunction

    function automatic logic [1:0] range_of(logic [1:0] rng);
        return (rng == RANGE_ALT_2G) ? RANGE_2G : rng;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/asc_if.sv
// Valid/ready channel interfaces for raw samples and converted results.
// No dependencies.
`default_nettype none

interface asc_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [7:0]         format_bits;

    modport source (output valid, accel_x, accel_y, accel_z, format_bits, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, format_bits, output ready);
endinterface

interface asc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  x_whole;
    logic [23:0] x_fraction;
    logic [7:0]  y_whole;
    logic [23:0] y_fraction;
    logic [7:0]  z_whole;
    logic [23:0] z_fraction;
    logic        over_threshold;
    logic [1:0]  range_code;
    logic [7:0]  sample_sequence;

    modport source (output valid, x_whole, x_fraction, y_whole, y_fraction, z_whole,
                    z_fraction, over_threshold, range_code, sample_sequence,
                    input ready);
    modport sink   (input valid, x_whole, x_fraction, y_whole, y_fraction, z_whole,
                    z_fraction, over_threshold, range_code, sample_sequence,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/core/asc_front.sv
// Front end: accepts sample transactions, decodes the format byte, takes
// axis magnitudes and assigns the sequence number. Depends on asc_pkg, asc_if.
`default_nettype none

module asc_front
    import asc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    asc_in_if.sink    sample,
    input  wire logic q_full,
    output logic      q_push,
    output item_t     q_entry
);

    logic [7:0]  seq_reg;
    logic [7:0]  seq_next;
    logic [3:0]  shift;
    logic [15:0] low_mask;
    logic [15:0] raw [AXES];

    assign sample.ready = !q_full;
    assign q_push       = sample.valid && !q_full;

    assign shift    = shift_of(sample.format_bits[1:0], sample.format_bits[3:2]);
    assign low_mask = (16'd1 << shift) - 16'd1;
    assign raw[0]   = sample.accel_x;
    assign raw[1]   = sample.accel_y;
    assign raw[2]   = sample.accel_z;
    assign seq_next = seq_reg + 8'd1;

    always_comb
    begin
        q_entry.shift      = shift;
        q_entry.scale      = scale_of(sample.format_bits[5:4]);
        q_entry.range_code = range_of(sample.format_bits[1:0]);
        q_entry.seq        = seq_next;
        for (int a = 0; a < AXES; a++)
        begin
            // The most negative sample negates to 0x8000, which is its true magnitude.
            q_entry.axes[a].neg = raw[a][15];
            q_entry.axes[a].mag = raw[a][15] ? (16'd0 - raw[a]) : raw[a];
            q_entry.axes[a].low = q_entry.axes[a].mag & low_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= 8'd0;
        end
        else if (q_push)
        begin
            seq_reg <= seq_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/asc_queue.sv
// Small in-order queue of decoded items between the front and back ends.
// Depends on asc_pkg.
`default_nettype none

module asc_queue
    import asc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  item_t     push_data,
    input  wire logic pop,
    output logic      full,
    output logic      head_valid,
    output item_t     head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slots[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/asc_back.sv
// Back end: walks the three axes of the head item through one pair of
// multipliers, finishes whole/fraction/threshold per axis and holds the
// result transaction in an output register. Depends on asc_pkg, asc_if.
`default_nettype none

module asc_back
    import asc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        head_valid,
    input  item_t            head,
    output logic             pop,
    input  wire logic [27:0] threshold,
    asc_out_if.source        result
);

    // Issue stage.
    axis_t       issue_idx_reg;
    axis_t       issue_idx_next;
    axis_entry_t sel;
    logic        advance;
    logic        issue;
    logic [32:0] mul_full;
    logic [32:0] mul_low;

    // Multiply stage registers.
    logic        s1_valid_reg;
    axis_t       s1_axis_reg;
    logic [31:0] s1_prod_full_reg;
    logic [31:0] s1_prod_low_reg;
    logic [11:0] s1_whole_reg;
    logic        s1_neg_reg;
    logic [3:0]  s1_shift_reg;
    logic [1:0]  s1_range_reg;
    logic [7:0]  s1_seq_reg;

    // Finish stage.
    logic [27:0] scaled;
    logic [16:0] rem;
    logic [23:0] frac;
    logic [7:0]  whole_byte;
    logic        hit;
    logic        s1_last;

    // Partial result for the first two axes.
    logic [7:0]  asm_whole_reg [2];
    logic [23:0] asm_frac_reg  [2];
    logic        hit_acc_reg;

    logic        out_valid_reg;
    logic [7:0]  out_x_whole_reg;
    logic [23:0] out_x_frac_reg;
    logic [7:0]  out_y_whole_reg;
    logic [23:0] out_y_frac_reg;
    logic [7:0]  out_z_whole_reg;
    logic [23:0] out_z_frac_reg;
    logic        out_hit_reg;
    logic [1:0]  out_range_reg;
    logic [7:0]  out_seq_reg;

    assign s1_last = s1_valid_reg && (s1_axis_reg == AXIS_Z);

    // The whole pipe holds while a finished item waits for a full output register.
    assign advance = !(s1_last && out_valid_reg && !result.ready);
    assign issue   = advance && head_valid;
    assign pop     = issue && (issue_idx_reg == AXIS_Z);

    always_comb
    begin
        unique case (issue_idx_reg)
            AXIS_X:  begin sel = head.axes[0]; issue_idx_next = AXIS_Y; end
            AXIS_Y:  begin sel = head.axes[1]; issue_idx_next = AXIS_Z; end
            AXIS_Z:  begin sel = head.axes[2]; issue_idx_next = AXIS_X; end
            default: begin sel = head.axes[0]; issue_idx_next = AXIS_X; end
        endcase
    end

    assign mul_full = 33'(sel.mag) * 33'(head.scale);
    assign mul_low  = 33'(sel.low) * 33'(head.scale);

    // mag * scale and low * scale both stay below 2^32.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_axis_reg      <= issue_idx_reg;
            s1_prod_full_reg <= mul_full[31:0];
            s1_prod_low_reg  <= mul_low[31:0];
            s1_whole_reg     <= 12'(sel.mag >> head.shift);
            s1_neg_reg       <= sel.neg;
            s1_shift_reg     <= head.shift;
            s1_range_reg     <= head.range_code;
            s1_seq_reg       <= head.seq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_idx_reg <= AXIS_X;
            s1_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= issue;
            if (issue)
            begin
                issue_idx_reg <= issue_idx_next;
            end
        end
    end

    // The fraction is floor(low * scale / 2^shift) times one hundred; the floor
    // equals the scaled value minus whole * scale without a second wide product.
    always_comb
    begin
        scaled     = 28'(s1_prod_full_reg >> s1_shift_reg);
        rem        = 17'(s1_prod_low_reg >> s1_shift_reg);
        frac       = (24'(rem) << 6) + (24'(rem) << 5) + (24'(rem) << 2);
        whole_byte = {s1_neg_reg,
                      (s1_whole_reg > 12'(WHOLE_MAX)) ? WHOLE_MAX : s1_whole_reg[6:0]};
        hit        = (scaled >= threshold);
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            unique case (s1_axis_reg)
                AXIS_X:
                begin
                    asm_whole_reg[0] <= whole_byte;
                    asm_frac_reg[0]  <= frac;
                    hit_acc_reg      <= hit;
                end
                AXIS_Y:
                begin
                    asm_whole_reg[1] <= whole_byte;
                    asm_frac_reg[1]  <= frac;
                    hit_acc_reg      <= hit_acc_reg | hit;
                end
                AXIS_Z:
                begin
                    out_x_whole_reg <= asm_whole_reg[0];
                    out_x_frac_reg  <= asm_frac_reg[0];
                    out_y_whole_reg <= asm_whole_reg[1];
                    out_y_frac_reg  <= asm_frac_reg[1];
                    out_z_whole_reg <= whole_byte;
                    out_z_frac_reg  <= frac;
                    out_hit_reg     <= hit_acc_reg | hit;
                    out_range_reg   <= s1_range_reg;
                    out_seq_reg     <= s1_seq_reg;
                end
                default:
                begin
                    hit_acc_reg <= hit_acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && s1_last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.x_whole         = out_x_whole_reg;
    assign result.x_fraction      = out_x_frac_reg;
    assign result.y_whole         = out_y_whole_reg;
    assign result.y_fraction      = out_y_frac_reg;
    assign result.z_whole         = out_z_whole_reg;
    assign result.z_fraction      = out_z_frac_reg;
    assign result.over_threshold  = out_hit_reg;
    assign result.range_code      = out_range_reg;
    assign result.sample_sequence = out_seq_reg;

endmodule

`default_nettype wire

FILE: rtl/core/accel_sample_scaler_unit.sv
// Top level of the accelerometer sample scaler: front end, item queue,
// back end and the threshold register. Depends on asc_pkg, asc_if and the
// asc_front, asc_queue and asc_back modules.
//
//   Channel   Dir  Handshake          Payload
//   sample    in   valid/ready        accel_x/y/z, format_bits
//   result    out  valid/ready        x/y/z whole+fraction, flag, range, sequence
//   cfg       in   cfg_we only        cfg_wdata -> sensitivity threshold
//
// A sample transaction passes through the back end one axis at a time, through
// the shared multiplier pair, and the finished result is held in the output
// register until it is taken. Reset clears the queue, the pipe and the sequence
// count and loads the threshold with 1000. A stalled result holds the pipe;
// samples keep being taken until the queue of QUEUE_DEPTH items fills.
`default_nettype none

module accel_sample_scaler_unit
    import asc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    asc_in_if.sink           sample,
    asc_out_if.source        result,
    input  wire logic        cfg_we,
    input  wire logic [27:0] cfg_wdata
);

    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_head_valid;
    item_t       q_entry;
    item_t       q_head;
    logic [27:0] threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= 28'd1000;
        end
        else if (cfg_we)
        begin
            threshold_reg <= cfg_wdata;
        end
    end

    asc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    asc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_entry),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    asc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .threshold  (threshold_reg),
        .result     (result)
    );

endmodule

`default_nettype wire

FILE: rtl/core/asc_checker.sv
// Port-level checks for the accelerometer sample scaler, bound to the top
// level. Depends only on the top level's ports.
`default_nettype none

module asc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        sample_valid,
    input wire logic        sample_ready,
    input wire logic        result_valid,
    input wire logic        result_ready,
    input wire logic [7:0]  x_whole,
    input wire logic [23:0] x_fraction,
    input wire logic [23:0] y_fraction,
    input wire logic [23:0] z_fraction,
    input wire logic [1:0]  range_code,
    input wire logic [7:0]  sample_sequence
);

    logic       in_acc;
    logic       out_acc;
    logic [7:0] pending_reg;
    logic [7:0] last_seq_reg;
    logic       seen_reg;

    assign in_acc  = sample_valid && sample_ready;
    assign out_acc = result_valid && result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= 8'd0;
            last_seq_reg <= 8'd0;
            seen_reg     <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_reg + 8'(in_acc) - 8'(out_acc);
            if (out_acc)
            begin
                last_seq_reg <= sample_sequence;
                seen_reg     <= 1'b1;
            end
        end
    end

    // Every result transaction answers an earlier sample transaction.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> pending_reg != 8'd0)
        else $error("result without an outstanding sample");

    // Results come out in order with consecutive sequence numbers.
    a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && seen_reg) |-> sample_sequence == last_seq_reg + 8'd1)
        else $error("sequence number skipped or repeated");

    a_range_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> range_code != 2'd3)
        else $error("range code out of range");

    // The fraction is a remainder below the decimal scale, times one hundred.
    a_fraction_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (x_fraction <= 24'd9999900) && (y_fraction <= 24'd9999900)
                         && (z_fraction <= 24'd9999900))
        else $error("fraction above its bound");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            result_valid && $stable(sample_sequence) && $stable(x_whole))
        else $error("stalled result transaction changed");

endmodule

bind accel_sample_scaler_unit asc_checker u_asc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .sample_valid    (sample.valid),
    .sample_ready    (sample.ready),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .x_whole         (result.x_whole),
    .x_fraction      (result.x_fraction),
    .y_fraction      (result.y_fraction),
    .z_fraction      (result.z_fraction),
    .range_code      (result.range_code),
    .sample_sequence (result.sample_sequence)
);

`default_nettype wire
